### rtl/core/lsf_pkg.sv
// Package with the shared types and constants of the line-fit block.
`default_nettype none
package lsf_pkg;

   localparam int unsigned XW       = 24;   // width of one Q8.16 coordinate
   localparam int unsigned CNT_W    = 11;   // width of the point counter
   localparam int unsigned SUM1_W   = 34;   // width of the sums of x and y
   localparam int unsigned SUM2_W   = 58;   // width of the sums of products
   localparam int unsigned PROD_W   = 48;   // width of one coordinate product
   localparam int unsigned WIDE_W   = 160;  // width of the wide fit arithmetic
   localparam int unsigned ITER_W   = 8;    // counter width for WIDE_W iterations
   localparam int unsigned QW       = 32;   // width of a Q16.16 result
   localparam int unsigned FQ_W     = 17;   // width of the R-squared result
   localparam int unsigned STAT_W   = 3;    // width of the status code

   localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STAT_W-1:0] STAT_X_EQUAL    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_Y_EQUAL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_SLOPE_ZERO = 3'd3;
   localparam logic [STAT_W-1:0] STAT_SATURATED  = 3'd4;
   localparam logic [STAT_W-1:0] STAT_DROPPED    = 3'd5;

   typedef logic signed [WIDE_W-1:0] lsf_wide_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_SUB,
      OP_RDIV
   } lsf_op_type;

   typedef struct packed {
      logic       start;
      lsf_op_type op;
   } lsf_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lsf_sts_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_SUB,
      U_ABSN,
      U_ABSD,
      U_PREP,
      U_DIV,
      U_FIX
   } lsf_alu_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD_XY,
      ST_PROD_XX,
      ST_PROD_YY,
      ST_ADD_YY,
      ST_START,
      ST_ISSUE,
      ST_WAIT
   } lsf_state_type;

   typedef enum logic [4:0] {
      STP_NSXX,
      STP_SXSX,
      STP_DX,
      STP_NSYY,
      STP_SYSY,
      STP_DY,
      STP_NSXY,
      STP_SXSY,
      STP_NA,
      STP_SYSXX,
      STP_SXSXY,
      STP_NB,
      STP_ICPT,
      STP_NAK,
      STP_SLOPE,
      STP_NEGNB,
      STP_ZC,
      STP_NANA,
      STP_R2K,
      STP_DXDY,
      STP_R2,
      STP_FINISH
   } lsf_step_type;

endpackage
`default_nettype wire

### rtl/core/lsf_if.sv
// Channel interfaces for the point input and the fit result of the line-fit block.
`default_nettype none
interface lsf_req_if;
   import lsf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [XW-1:0] x_value;
   logic signed [XW-1:0] y_value;
   logic                 last_point;
   modport source (output valid, output x_value, output y_value, output last_point,
                   input ready);
   modport sink   (input valid, input x_value, input y_value, input last_point,
                   output ready);
endinterface

interface lsf_rsp_if;
   import lsf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [QW-1:0]    slope;
   logic signed [QW-1:0]    intercept;
   logic [FQ_W-1:0]         fit_quality;
   logic signed [QW-1:0]    zero_crossing;
   logic [CNT_W-1:0]        points_used;
   logic [STAT_W-1:0]       status;
   modport source (output valid, output slope, output intercept, output fit_quality,
                   output zero_crossing, output points_used, output status,
                   input ready);
   modport sink   (input valid, input slope, input intercept, input fit_quality,
                   input zero_crossing, input points_used, input status,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/lsf_seq_alu.sv
// Iterative wide arithmetic unit: multiply, subtract and rounded divide on one adder.
`default_nettype none
module lsf_seq_alu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lsf_pkg::lsf_cmd_type cmd,
   input  wire lsf_pkg::lsf_wide_type opa,
   input  wire lsf_pkg::lsf_wide_type opb,
   output lsf_pkg::lsf_sts_type      sts,
   output lsf_pkg::lsf_wide_type     result
);
   import lsf_pkg::*;

   lsf_alu_state_type   state_ff, state_in;
   logic [WIDE_W-1:0]   a_ff, b_ff, acc_ff, q_ff, res_ff;
   logic [ITER_W-1:0]   cnt_ff;
   logic                neg_ff, done_ff;
   logic [WIDE_W-1:0]   add_x, add_y, rem_sh;
   logic                inv, finish;
   logic [WIDE_W:0]     sum;

   localparam logic [ITER_W-1:0] LastIter = ITER_W'(WIDE_W - 1);

   // Single shared adder; subtraction by inverting the second operand.
   always_comb begin
      rem_sh = {acc_ff[WIDE_W-2:0], a_ff[WIDE_W-1]};
      add_x  = '0;
      add_y  = '0;
      inv    = 1'b0;
      case (state_ff)
         U_MUL:  begin add_x = acc_ff;                  add_y = a_ff; end
         U_SUB:  begin add_x = a_ff;                    add_y = b_ff; inv = 1'b1; end
         U_ABSN: begin add_x = '0;                      add_y = a_ff; inv = 1'b1; end
         U_ABSD: begin add_x = '0;                      add_y = b_ff; inv = 1'b1; end
         U_PREP: begin add_x = {a_ff[WIDE_W-2:0], 1'b0}; add_y = b_ff; end
         U_DIV:  begin add_x = rem_sh;                  add_y = b_ff; inv = 1'b1; end
         U_FIX:  begin add_x = '0;                      add_y = q_ff; inv = 1'b1; end
         default: begin add_x = '0; add_y = '0; inv = 1'b0; end
      endcase
      sum = {1'b0, add_x} + {1'b0, add_y ^ {WIDE_W{inv}}} + {{WIDE_W{1'b0}}, inv};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_MUL:  state_in = U_MUL;
                  OP_SUB:  state_in = U_SUB;
                  OP_RDIV: state_in = U_ABSN;
                  default: state_in = U_IDLE;
               endcase
            end
         end
         U_MUL:   if (cnt_ff == '0) state_in = U_IDLE;
         U_SUB:   state_in = U_IDLE;
         U_ABSN:  state_in = U_ABSD;
         U_ABSD:  state_in = U_PREP;
         U_PREP:  state_in = U_DIV;
         U_DIV:   if (cnt_ff == '0) state_in = U_FIX;
         U_FIX:   state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      finish = ((state_ff == U_MUL) && (cnt_ff == '0)) || (state_ff == U_SUB) ||
               (state_ff == U_FIX);
      sts.busy = (state_ff != U_IDLE);
      sts.done = done_ff;
      result   = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= finish;
      end
      case (state_ff)
         U_IDLE: begin
            a_ff   <= opa;
            b_ff   <= opb;
            acc_ff <= '0;
            cnt_ff <= LastIter;
            neg_ff <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
         end
         U_MUL: begin
            // Two's complement product modulo 2**WIDE_W, one multiplier bit a cycle.
            if (b_ff[0]) acc_ff <= sum[WIDE_W-1:0];
            a_ff   <= {a_ff[WIDE_W-2:0], 1'b0};
            b_ff   <= {1'b0, b_ff[WIDE_W-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) res_ff <= b_ff[0] ? sum[WIDE_W-1:0] : acc_ff;
         end
         U_SUB:  res_ff <= sum[WIDE_W-1:0];
         U_ABSN: if (a_ff[WIDE_W-1]) a_ff <= sum[WIDE_W-1:0];
         U_ABSD: if (b_ff[WIDE_W-1]) b_ff <= sum[WIDE_W-1:0];
         U_PREP: begin
            // Rounding half away from zero: (2|n| + |d|) / (2|d|).
            a_ff   <= sum[WIDE_W-1:0];
            b_ff   <= {b_ff[WIDE_W-2:0], 1'b0};
            acc_ff <= '0;
            q_ff   <= '0;
            cnt_ff <= LastIter;
         end
         U_DIV: begin
            a_ff   <= {a_ff[WIDE_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (sum[WIDE_W]) begin
               acc_ff <= sum[WIDE_W-1:0];
               q_ff   <= {q_ff[WIDE_W-2:0], 1'b1};
            end else begin
               acc_ff <= rem_sh;
               q_ff   <= {q_ff[WIDE_W-2:0], 1'b0};
            end
         end
         U_FIX:  res_ff <= neg_ff ? sum[WIDE_W-1:0] : q_ff;
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/least_squares_line_fit.sv
// Top level of the streaming least-squares straight-line fit.
// An accumulated point runs through PROD_XY, PROD_XX, PROD_YY and ADD_YY before the input is ready again;
// a point dropped for full capacity leaves the input ready. The point marked last then starts the fit:
// 12 multiplies, 5 subtracts and 4 divides on the shared 160-bit unit; the x all equal case ends
// after the NB subtract, and the y all equal and zero slope cases end after the intercept divide.
// Synchronous active-high reset clears the sums, the counter, the drop flag and the result valid.
`default_nettype none
module least_squares_line_fit #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lsf_req_if.sink    req_ch,
   lsf_rsp_if.source  rsp_ch
);
   import lsf_pkg::*;

   localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_POINTS);
   localparam lsf_wide_type      K16      = lsf_wide_type'(65536);

   // Accumulation state.
   lsf_state_type              state_ff, state_in;
   lsf_step_type               step_ff;
   logic [CNT_W-1:0]           count_ff;
   logic signed [SUM1_W-1:0]   sx_ff, sy_ff;
   logic signed [SUM2_W-1:0]   sxy_ff, sxx_ff, syy_ff;
   logic                       ovf_ff;
   logic signed [XW-1:0]       x_ff, y_ff;
   logic                       last_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [XW-1:0]       mul_a, mul_b;

   // Fit working registers.
   lsf_wide_type               tp_ff, dx_ff, dy_ff, na_ff, nb_ff;
   logic [QW-1:0]              slope_ff, icpt_ff, zc_ff;
   logic                       slope_sat_ff, icpt_sat_ff, zc_sat_ff;
   logic [FQ_W-1:0]            fq_ff;
   logic [STAT_W-1:0]          stat_ff;

   // Result register.
   logic                       rsp_valid_ff;
   logic [QW-1:0]              out_slope_ff, out_icpt_ff, out_zc_ff;
   logic [FQ_W-1:0]            out_fq_ff;
   logic [CNT_W-1:0]           out_count_ff;
   logic [STAT_W-1:0]          out_stat_ff;

   // Shared unit connections.
   lsf_cmd_type                cmd;
   lsf_sts_type                sts;
   lsf_wide_type               opa, opb, alu_res;
   lsf_wide_type               n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w;

   logic                       req_xfer, full, load_out;
   logic [QW:0]                res_q;
   logic [FQ_W-1:0]            res_fq;

   lsf_seq_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .sts    (sts),
      .result (alu_res)
   );

   // Saturate a wide quotient to Q16.16; the top bit reports saturation.
   function automatic logic [QW:0] to_q(input lsf_wide_type v);
      logic fits;
      fits = (&v[WIDE_W-1:QW-1]) || !(|v[WIDE_W-1:QW-1]);
      if (fits) to_q = {1'b0, v[QW-1:0]};
      else if (v[WIDE_W-1]) to_q = {1'b1, 1'b1, {(QW-1){1'b0}}};
      else to_q = {1'b1, 1'b0, {(QW-1){1'b1}}};
   endfunction

   always_comb begin
      n_w   = {{(WIDE_W-CNT_W){1'b0}}, count_ff};
      sx_w  = {{(WIDE_W-SUM1_W){sx_ff[SUM1_W-1]}}, sx_ff};
      sy_w  = {{(WIDE_W-SUM1_W){sy_ff[SUM1_W-1]}}, sy_ff};
      sxy_w = {{(WIDE_W-SUM2_W){sxy_ff[SUM2_W-1]}}, sxy_ff};
      sxx_w = {{(WIDE_W-SUM2_W){sxx_ff[SUM2_W-1]}}, sxx_ff};
      syy_w = {{(WIDE_W-SUM2_W){syy_ff[SUM2_W-1]}}, syy_ff};
      res_q = to_q(alu_res);
      // R-squared is clamped to exactly one; a negative quotient reads as zero.
      if (alu_res[WIDE_W-1]) res_fq = '0;
      else if ((|alu_res[WIDE_W-1:FQ_W]) || (alu_res[FQ_W-1:0] > 17'd65536))
         res_fq = 17'd65536;
      else res_fq = alu_res[FQ_W-1:0];
   end

   // Command and operand selection for the current step of the fit program.
   always_comb begin
      cmd.start = (state_ff == ST_ISSUE) && (step_ff != STP_FINISH) && !sts.busy;
      cmd.op    = OP_MUL;
      opa       = '0;
      opb       = '0;
      case (step_ff)
         STP_NSXX:  begin opa = n_w;   opb = sxx_w; end
         STP_SXSX:  begin opa = sx_w;  opb = sx_w;  end
         STP_DX:    begin cmd.op = OP_SUB; opa = tp_ff; opb = alu_res; end
         STP_NSYY:  begin opa = n_w;   opb = syy_w; end
         STP_SYSY:  begin opa = sy_w;  opb = sy_w;  end
         STP_DY:    begin cmd.op = OP_SUB; opa = tp_ff; opb = alu_res; end
         STP_NSXY:  begin opa = n_w;   opb = sxy_w; end
         STP_SXSY:  begin opa = sx_w;  opb = sy_w;  end
         STP_NA:    begin cmd.op = OP_SUB; opa = tp_ff; opb = alu_res; end
         STP_SYSXX: begin opa = sy_w;  opb = sxx_w; end
         STP_SXSXY: begin opa = sx_w;  opb = sxy_w; end
         STP_NB:    begin cmd.op = OP_SUB; opa = tp_ff; opb = alu_res; end
         STP_ICPT:  begin cmd.op = OP_RDIV; opa = nb_ff; opb = dx_ff; end
         STP_NAK:   begin opa = na_ff; opb = K16;   end
         STP_SLOPE: begin cmd.op = OP_RDIV; opa = tp_ff; opb = dx_ff; end
         STP_NEGNB: begin cmd.op = OP_SUB; opa = '0; opb = nb_ff; end
         STP_ZC:    begin cmd.op = OP_RDIV; opa = tp_ff; opb = na_ff; end
         STP_NANA:  begin opa = na_ff; opb = na_ff; end
         STP_R2K:   begin opa = tp_ff; opb = K16;   end
         STP_DXDY:  begin opa = dx_ff; opb = dy_ff; end
         STP_R2:    begin cmd.op = OP_RDIV; opa = tp_ff; opb = nb_ff; end
         default:   begin cmd.op = OP_MUL; opa = '0; opb = '0; end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!full) state_in = ST_PROD_XY;
               else if (req_ch.last_point) state_in = ST_START;
            end
         end
         ST_PROD_XY: state_in = ST_PROD_XX;
         ST_PROD_XX: state_in = ST_PROD_YY;
         ST_PROD_YY: state_in = ST_ADD_YY;
         ST_ADD_YY:  state_in = last_ff ? ST_START : ST_IDLE;
         ST_START:   state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (step_ff == STP_FINISH) begin
               if (load_out) state_in = ST_IDLE;
            end else if (!sts.busy) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT:    if (sts.done) state_in = ST_ISSUE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Handshake and control outputs.
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      req_xfer     = req_ch.valid && req_ch.ready;
      full         = (count_ff >= MaxCount);
      load_out     = (state_ff == ST_ISSUE) && (step_ff == STP_FINISH) &&
                     (!rsp_valid_ff || rsp_ch.ready);
      mul_a        = x_ff;
      mul_b        = y_ff;
      case (state_ff)
         ST_PROD_XX: begin mul_a = x_ff; mul_b = x_ff; end
         ST_PROD_YY: begin mul_a = y_ff; mul_b = y_ff; end
         default:    begin mul_a = x_ff; mul_b = y_ff; end
      endcase
      rsp_ch.valid         = rsp_valid_ff;
      rsp_ch.slope         = out_slope_ff;
      rsp_ch.intercept     = out_icpt_ff;
      rsp_ch.fit_quality   = out_fq_ff;
      rsp_ch.zero_crossing = out_zc_ff;
      rsp_ch.points_used   = out_count_ff;
      rsp_ch.status        = out_stat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxy_ff       <= '0;
         sxx_ff       <= '0;
         syy_ff       <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= STP_NSXX;
      end else begin
         state_ff <= state_in;

         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;

         // The first-order sums update at the transfer; products follow one a cycle.
         if (req_xfer) begin
            if (!full) begin
               count_ff <= count_ff + 1'b1;
               sx_ff    <= sx_ff + {{(SUM1_W-XW){req_ch.x_value[XW-1]}}, req_ch.x_value};
               sy_ff    <= sy_ff + {{(SUM1_W-XW){req_ch.y_value[XW-1]}}, req_ch.y_value};
            end else begin
               ovf_ff   <= 1'b1;
            end
         end
         case (state_ff)
            ST_PROD_XX: sxy_ff <= sxy_ff + {{(SUM2_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            ST_PROD_YY: sxx_ff <= sxx_ff + {{(SUM2_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            ST_ADD_YY:  syy_ff <= syy_ff + {{(SUM2_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            default: begin
            end
         endcase

         if (state_ff == ST_START) step_ff <= STP_NSXX;

         // Step sequencing with the early exits of the degenerate cases.
         if ((state_ff == ST_WAIT) && sts.done) begin
            case (step_ff)
               STP_NB:   step_ff <= (dx_ff == '0) ? STP_FINISH : STP_ICPT;
               STP_ICPT: step_ff <= ((dy_ff == '0) || (na_ff == '0)) ? STP_FINISH : STP_NAK;
               STP_R2:   step_ff <= STP_FINISH;
               default:  step_ff <= lsf_step_type'(step_ff + 5'd1);
            endcase
         end

         // A delivered fit clears every sum for the next data set.
         if (load_out) begin
            count_ff <= '0;
            sx_ff    <= '0;
            sy_ff    <= '0;
            sxy_ff   <= '0;
            sxx_ff   <= '0;
            syy_ff   <= '0;
            ovf_ff   <= 1'b0;
         end
      end

      if (req_xfer) begin
         x_ff    <= req_ch.x_value;
         y_ff    <= req_ch.y_value;
         last_ff <= req_ch.last_point;
      end
      prod_ff <= mul_a * mul_b;

      if (state_ff == ST_START) begin
         slope_ff     <= '0;
         icpt_ff      <= '0;
         zc_ff        <= '0;
         fq_ff        <= '0;
         slope_sat_ff <= 1'b0;
         icpt_sat_ff  <= 1'b0;
         zc_sat_ff    <= 1'b0;
         stat_ff      <= STAT_OK;
      end

      if ((state_ff == ST_WAIT) && sts.done) begin
         case (step_ff)
            STP_NSXX, STP_NSYY, STP_NSXY, STP_SYSXX, STP_NAK, STP_NEGNB, STP_NANA,
            STP_R2K:  tp_ff <= alu_res;
            STP_DX:   dx_ff <= alu_res;
            STP_DY:   dy_ff <= alu_res;
            STP_NA:   na_ff <= alu_res;
            STP_NB: begin
               nb_ff <= alu_res;
               if (dx_ff == '0) stat_ff <= STAT_X_EQUAL;
            end
            STP_DXDY: nb_ff <= alu_res;
            STP_ICPT: begin
               icpt_ff     <= res_q[QW-1:0];
               icpt_sat_ff <= res_q[QW];
               if (dy_ff == '0) stat_ff <= STAT_Y_EQUAL;
               else if (na_ff == '0) stat_ff <= STAT_SLOPE_ZERO;
            end
            STP_SLOPE: begin
               slope_ff     <= res_q[QW-1:0];
               slope_sat_ff <= res_q[QW];
            end
            STP_ZC: begin
               zc_ff     <= res_q[QW-1:0];
               zc_sat_ff <= res_q[QW];
            end
            STP_R2: begin
               fq_ff <= res_fq;
               // Dropped points outrank saturation in the reported status.
               if (ovf_ff) stat_ff <= STAT_DROPPED;
               else if (slope_sat_ff || icpt_sat_ff || zc_sat_ff) stat_ff <= STAT_SATURATED;
               else stat_ff <= STAT_OK;
            end
            default: begin
            end
         endcase
      end

      if (load_out) begin
         out_slope_ff <= slope_ff;
         out_icpt_ff  <= icpt_ff;
         out_zc_ff    <= zc_ff;
         out_fq_ff    <= fq_ff;
         out_count_ff <= count_ff;
         out_stat_ff  <= stat_ff;
      end
   end

endmodule
`default_nettype wire
